// File: src/apf_pkg.sv
// ----------------------------------------------------------------------------
// apf_pkg
// Shared constants, register indexes and control types for the second-order
// allpass filter.
// ----------------------------------------------------------------------------
`default_nettype none

package apf_pkg;

    localparam int CHANNELS_DEF       = 2;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // coefficient reset values, given in Q2.16 and rescaled at elaboration
    localparam longint COEF_C_RESET_Q16 = -57476;
    localparam longint COEF_D_RESET_Q16 = -64975;
    localparam int     RESET_FRAC_BITS  = 16;

    // configuration register indexes
    localparam int                CFG_INDEX_W = 2;
    localparam [CFG_INDEX_W-1:0]  REG_COEF_C  = 2'd0;
    localparam [CFG_INDEX_W-1:0]  REG_COEF_D  = 2'd1;

    // operand selections for the shared multiplier
    localparam int              MUL_SEL_W   = 2;
    localparam [MUL_SEL_W-1:0]  MUL_D_ONEMC = 2'd0;  // d * (1 - c)
    localparam [MUL_SEL_W-1:0]  MUL_K_H1    = 2'd1;  // k * h1
    localparam [MUL_SEL_W-1:0]  MUL_C_H2    = 2'd2;  // c * h2
    localparam [MUL_SEL_W-1:0]  MUL_C_H     = 2'd3;  // c * h

    typedef struct packed {
        logic                 load;
        logic                 mul_en;
        logic [MUL_SEL_W-1:0] mul_sel;
        logic                 k_en;
        logic                 acc_en;
        logic                 h_en;
        logic                 y_en;
    } ctrl_t;

endpackage

`default_nettype wire

// File: src/apf_mul.sv
// ----------------------------------------------------------------------------
// apf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module apf_mul #(
    parameter int A_W = 20,
    parameter int B_W = 28
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [A_W-1:0]    a,
    input  wire logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0]     prod
);

    logic signed [A_W+B_W-1:0] prod_reg;
    logic signed [A_W+B_W-1:0] prod_next;

    assign prod_next = (A_W+B_W)'(a) * (A_W+B_W)'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: src/apf_seq.sv
// ----------------------------------------------------------------------------
// apf_seq
// Step sequencer: accepts a word, walks the multiply/accumulate steps and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module apf_seq (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output apf_pkg::ctrl_t ctrl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MK   = 3'd1;
    localparam logic [2:0] ST_RK   = 3'd2;
    localparam logic [2:0] ST_MKH1 = 3'd3;
    localparam logic [2:0] ST_MCH2 = 3'd4;
    localparam logic [2:0] ST_H    = 3'd5;
    localparam logic [2:0] ST_MCH  = 3'd6;
    localparam logic [2:0] ST_Y    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        ctrl         = '0;
        ctrl.mul_sel = apf_pkg::MUL_D_ONEMC;
        state_next   = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_MK;
                end
            end
            ST_MK:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = apf_pkg::MUL_D_ONEMC;
                state_next   = ST_RK;
            end
            ST_RK:
            begin
                ctrl.k_en  = 1'b1;
                state_next = ST_MKH1;
            end
            ST_MKH1:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = apf_pkg::MUL_K_H1;
                state_next   = ST_MCH2;
            end
            ST_MCH2:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = apf_pkg::MUL_C_H2;
                ctrl.acc_en  = 1'b1;
                state_next   = ST_H;
            end
            ST_H:
            begin
                ctrl.h_en  = 1'b1;
                state_next = ST_MCH;
            end
            ST_MCH:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = apf_pkg::MUL_C_H;
                state_next   = ST_Y;
            end
            ST_Y:
            begin
                // hold here until the output register can take the word
                if (out_free)
                begin
                    ctrl.y_en  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.y_en)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// File: src/second_order_allpass_filter_top.sv
// ----------------------------------------------------------------------------
// second_order_allpass_filter_top
// Per-channel second-order allpass filter, h = x - k*h1 + c*h2,
// y = -c*h + k*h1 + h2 with k = d*(1-c), on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: channel, tdata: sample_in
//  m_*       out  m_tvalid/m_tready  tuser: channel_out, tdata: sample_out
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (coef_c, coef_d)
//
//  A word takes the accepting idle cycle plus seven steps with four
//  multiplier passes; its result is registered in the final step.
//  s_tready is high only in idle; a result waiting in the output register
//  stalls only the final step of the next word.
//  Reset clears both delay words of every channel and loads the default
//  coefficients. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module second_order_allpass_filter_top #(
    parameter int CHANNELS       = apf_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS    = apf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = apf_pkg::COEF_FRAC_BITS_DEF,
    localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int COEF_BITS     = COEF_FRAC_BITS + 2
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [DATA_W-1:0]               s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    input  wire logic                            s_tuser,   // [0] channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [DATA_W-1:0]                    m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    output logic                                 m_tuser,   // [0] channel_out
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [apf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COEF_BITS-1:0]            cfg_data
);

    localparam int F        = COEF_FRAC_BITS;
    localparam int DLY_W    = SAMPLE_BITS + 4;
    localparam int K_W      = F + 4;
    localparam int A_W      = K_W;
    localparam int B_W      = (DLY_W > COEF_BITS + 1) ? DLY_W : COEF_BITS + 1;
    localparam int P_W      = A_W + B_W;
    localparam int ACC_W    = P_W + 2;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam longint C_RST_L = (F >= apf_pkg::RESET_FRAC_BITS)
        ? apf_pkg::COEF_C_RESET_Q16 <<< (F - apf_pkg::RESET_FRAC_BITS)
        : apf_pkg::COEF_C_RESET_Q16 >>> (apf_pkg::RESET_FRAC_BITS - F);
    localparam longint D_RST_L = (F >= apf_pkg::RESET_FRAC_BITS)
        ? apf_pkg::COEF_D_RESET_Q16 <<< (F - apf_pkg::RESET_FRAC_BITS)
        : apf_pkg::COEF_D_RESET_Q16 >>> (apf_pkg::RESET_FRAC_BITS - F);
    localparam logic [COEF_BITS-1:0] C_RST = COEF_BITS'(C_RST_L);
    localparam logic [COEF_BITS-1:0] D_RST = COEF_BITS'(D_RST_L);

    localparam logic signed [COEF_BITS:0] ONE_Q = (COEF_BITS+1)'(1) <<< F;
    localparam logic signed [ACC_W-1:0]   HALF  = ACC_W'(1) <<< (F - 1);

    localparam logic signed [ACC_W-1:0] DLY_MAX =
        {{(ACC_W-DLY_W+1){1'b0}}, {(DLY_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DLY_MIN = ~DLY_MAX;
    localparam logic signed [ACC_W-1:0] SMP_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;

    apf_pkg::ctrl_t ctrl;

    logic signed [COEF_BITS-1:0]   coef_c_reg;
    logic signed [COEF_BITS-1:0]   coef_d_reg;
    logic signed [DLY_W-1:0]       delay_one_reg [CHANNELS];
    logic signed [DLY_W-1:0]       delay_two_reg [CHANNELS];

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          ch_reg;
    logic [CH_IDX_W-1:0]           idx_reg;
    logic [CH_IDX_W-1:0]           in_idx;
    logic signed [DLY_W-1:0]       h1_reg;
    logic signed [DLY_W-1:0]       h2_reg;
    logic signed [K_W-1:0]         k_reg;
    logic signed [K_W-1:0]         k_next;
    logic signed [P_W-1:0]         kh1_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [DLY_W-1:0]       h_reg;
    logic signed [DLY_W-1:0]       h_next;
    logic signed [ACC_W-1:0]       h_sum;
    logic signed [ACC_W-1:0]       h_rnd;
    logic signed [ACC_W-1:0]       y_sum;
    logic signed [ACC_W-1:0]       y_rnd;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic                          ch_out_reg;

    logic signed [COEF_BITS:0]     one_minus_c;
    logic signed [A_W-1:0]         mul_a;
    logic signed [B_W-1:0]         mul_b;
    logic signed [P_W-1:0]         prod;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_c_reg <= C_RST;
            coef_d_reg <= D_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == apf_pkg::REG_COEF_C)
            begin
                coef_c_reg <= cfg_data;
            end
            else if (cfg_index == apf_pkg::REG_COEF_D)
            begin
                coef_d_reg <= cfg_data;
            end
        end
    end

    apf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    // channel modulo CHANNELS; the field is one bit wide
    assign in_idx = (CHANNELS > 1) ? CH_IDX_W'(s_tuser) : '0;

    // shared multiplier operands
    assign one_minus_c = ONE_Q - (COEF_BITS+1)'(coef_c_reg);

    always_comb
    begin
        case (ctrl.mul_sel)
            apf_pkg::MUL_D_ONEMC:
            begin
                mul_a = A_W'(coef_d_reg);
                mul_b = B_W'(one_minus_c);
            end
            apf_pkg::MUL_K_H1:
            begin
                mul_a = A_W'(k_reg);
                mul_b = B_W'(h1_reg);
            end
            apf_pkg::MUL_C_H2:
            begin
                mul_a = A_W'(coef_c_reg);
                mul_b = B_W'(h2_reg);
            end
            apf_pkg::MUL_C_H:
            begin
                mul_a = A_W'(coef_c_reg);
                mul_b = B_W'(h_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    apf_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // round half up then floor by 2^F
    assign k_next   = K_W'((ACC_W'(prod) + HALF) >>> F);
    assign acc_next = (ACC_W'(x_reg) <<< F) - ACC_W'(prod);

    assign h_sum  = acc_reg + ACC_W'(prod);
    assign h_rnd  = (h_sum + HALF) >>> F;
    assign h_next = (h_rnd > DLY_MAX) ? DLY_W'(DLY_MAX) :
                    (h_rnd < DLY_MIN) ? DLY_W'(DLY_MIN) : DLY_W'(h_rnd);

    assign y_sum  = (ACC_W'(h2_reg) <<< F) + ACC_W'(kh1_reg) - ACC_W'(prod);
    assign y_rnd  = (y_sum + HALF) >>> F;
    assign y_next = (y_rnd > SMP_MAX) ? SAMPLE_BITS'(SMP_MAX) :
                    (y_rnd < SMP_MIN) ? SAMPLE_BITS'(SMP_MIN) : SAMPLE_BITS'(y_rnd);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg   <= s_tdata[SAMPLE_BITS-1:0];
            ch_reg  <= s_tuser;
            idx_reg <= in_idx;
            h1_reg  <= delay_one_reg[in_idx];
            h2_reg  <= delay_two_reg[in_idx];
        end
        if (ctrl.k_en)
        begin
            k_reg <= k_next;
        end
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
            kh1_reg <= prod;
        end
        if (ctrl.h_en)
        begin
            h_reg <= h_next;
        end
        if (ctrl.y_en)
        begin
            y_reg      <= y_next;
            ch_out_reg <= ch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                delay_one_reg[i] <= '0;
                delay_two_reg[i] <= '0;
            end
        end
        else if (ctrl.y_en)
        begin
            delay_one_reg[idx_reg] <= h_reg;
            delay_two_reg[idx_reg] <= h1_reg;
        end
    end

    assign m_tdata = DATA_W'(unsigned'(y_reg));
    assign m_tuser = ch_out_reg;

endmodule

`default_nettype wire
